// ===== rtl/assert_macros.svh =====
// assertion macros for the rtl top level
// clocked on i_clk, disabled while i_rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define FCS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FCS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/fcs_pkg.sv =====
// types, constants and helper functions of the free cell search block
// no dependencies
`timescale 1ns / 1ps

package fcs_pkg;

    localparam int GRID_CELLS_DEF   = 65536;
    localparam int EXTRA_PROBES_DEF = 19;

    // register indexes
    localparam logic [2:0] CFG_ORIGIN_X   = 3'd0;
    localparam logic [2:0] CFG_ORIGIN_Y   = 3'd1;
    localparam logic [2:0] CFG_CELL_SIZE  = 3'd2;
    localparam logic [2:0] CFG_GRID_W     = 3'd3;
    localparam logic [2:0] CFG_GRID_H     = 3'd4;
    localparam logic [2:0] CFG_PROBE_DIST = 3'd5;
    localparam logic [2:0] CFG_LETHAL     = 3'd6;
    localparam logic [2:0] CFG_INSCRIBED  = 3'd7;

    // request kinds
    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_SEARCH = 1'b1;

    // result status codes
    localparam logic [1:0] ST_FOUND = 2'd0;
    localparam logic [1:0] ST_NONE  = 2'd1;
    localparam logic [1:0] ST_SAME  = 2'd2;

    // reset values
    localparam logic [30:0] CELL_SIZE_RST  = 31'd3277;
    localparam logic [8:0]  GRID_W_RST     = 9'd256;
    localparam logic [8:0]  GRID_H_RST     = 9'd256;
    localparam logic [30:0] PROBE_DIST_RST = 31'd26214;
    localparam logic [7:0]  LETHAL_RST     = 8'd254;
    localparam logic [7:0]  INSCRIBED_RST  = 8'd253;

    // divider widths: unit vector needs a 61 bit dividend
    localparam int DIV_DW = 61;
    localparam int DIV_VW = 32;

    // cos of multiples of 18 degrees, q2.30
    localparam logic signed [31:0] COS_0  = 32'sd1073741824;
    localparam logic signed [31:0] COS_18 = 32'sd1021189159;
    localparam logic signed [31:0] COS_36 = 32'sd868675383;
    localparam logic signed [31:0] COS_54 = 32'sd631129609;
    localparam logic signed [31:0] COS_72 = 32'sd331804471;

    typedef struct packed {
        logic               req_type;
        logic               wr_ok;
        logic [15:0]        cell_index;
        logic [7:0]         cell_value;
        logic signed [31:0] goal_x;
        logic signed [31:0] goal_y;
        logic signed [31:0] robot_x;
        logic signed [31:0] robot_y;
    } t_item;

    typedef struct packed {
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic [30:0]        cell_size;
        logic [8:0]         grid_width;
        logic [8:0]         grid_height;
        logic [30:0]        probe_distance;
        logic [7:0]         lethal_code;
        logic [7:0]         inscribed_code;
    } t_cfg;

    typedef struct packed {
        logic [1:0]         search_status;
        logic signed [31:0] free_x;
        logic signed [31:0] free_y;
        logic [4:0]         probe_number;
    } t_result;

    typedef struct packed {
        logic              start;
        logic [DIV_DW-1:0] dividend;
        logic [DIV_VW-1:0] divisor;
    } t_div_req;

    // turn step for probe p: 0, 0, -1, +1, -2, +2 ... modulo 20
    function automatic logic [4:0] probe_angle(input logic [5:0] p);
        logic [4:0] m;
        logic [4:0] mm;
        logic [4:0] a;
        m  = p[5:1];
        mm = (m >= 5'd20) ? m - 5'd20 : m;
        if (p >= 6'd2 && !p[0]) begin
            a = (mm == 5'd0) ? 5'd0 : 5'd20 - mm;
        end else begin
            a = mm;
        end
        return a;
    endfunction

    function automatic logic signed [31:0] cos_q30(input logic [4:0] k);
        logic signed [31:0] c;
        case (k)
            5'd0:    c = COS_0;
            5'd1:    c = COS_18;
            5'd2:    c = COS_36;
            5'd3:    c = COS_54;
            5'd4:    c = COS_72;
            5'd5:    c = 32'sd0;
            5'd6:    c = -COS_72;
            5'd7:    c = -COS_54;
            5'd8:    c = -COS_36;
            5'd9:    c = -COS_18;
            5'd10:   c = -COS_0;
            5'd11:   c = -COS_18;
            5'd12:   c = -COS_36;
            5'd13:   c = -COS_54;
            5'd14:   c = -COS_72;
            5'd15:   c = 32'sd0;
            5'd16:   c = COS_72;
            5'd17:   c = COS_54;
            5'd18:   c = COS_36;
            5'd19:   c = COS_18;
            default: c = 32'sd0;
        endcase
        return c;
    endfunction

    // sin(k) = cos(k + 15) modulo 20
    function automatic logic [4:0] sin_index(input logic [4:0] k);
        return (k >= 5'd5) ? k - 5'd5 : k + 5'd15;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
        logic signed [31:0] r;
        if (v > 35'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -35'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/fcs_front.sv =====
// intake of request words: classifies each word and queues it for the back end
// depends on fcs_pkg
`timescale 1ns / 1ps

module fcs_front #(
    parameter int GRID_CELLS = fcs_pkg::GRID_CELLS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  fcs_pkg::t_item i_item,
    output logic          o_valid,
    output fcs_pkg::t_item o_item,
    input  logic          i_pop
);

    fcs_pkg::t_item r_q [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    logic           push;
    logic           pop;
    fcs_pkg::t_item cls;

    // mark writes that land inside the store
    always_comb begin
        cls       = i_item;
        cls.wr_ok = (32'(i_item.cell_index) < 32'(GRID_CELLS));
    end

    assign o_stall = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_q[r_rp];
    assign push    = i_valid && !o_stall;
    assign pop     = o_valid && i_pop;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

endmodule

// ===== rtl/fcs_div.sv =====
// shared restoring divider, one quotient bit per cycle
// depends on fcs_pkg
`timescale 1ns / 1ps

module fcs_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  fcs_pkg::t_div_req            i_req,
    output logic                         o_done,
    output logic [fcs_pkg::DIV_DW-1:0]   o_quo
);

    localparam int DW = fcs_pkg::DIV_DW;
    localparam int VW = fcs_pkg::DIV_VW;
    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] r_quo;
    logic [VW:0]   r_rem;
    logic [VW-1:0] r_div;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [VW:0]   rem_sh;
    logic          ge;

    assign rem_sh = {r_rem[VW-1:0], r_quo[DW-1]};
    assign ge     = (rem_sh >= {1'b0, r_div});
    assign o_done = r_done;
    assign o_quo  = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_quo  <= i_req.dividend;
                r_div  <= i_req.divisor;
                r_rem  <= '0;
                r_cnt  <= CW'(DW);
            end else if (r_busy) begin
                r_rem <= ge ? rem_sh - {1'b0, r_div} : rem_sh;
                r_quo <= {r_quo[DW-2:0], ge};
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

// ===== rtl/fcs_back.sv =====
// back end: cost store, square root, unit vector and probe sequencer
// depends on fcs_pkg and fcs_div
`timescale 1ns / 1ps

module fcs_back #(
    parameter int GRID_CELLS   = fcs_pkg::GRID_CELLS_DEF,
    parameter int EXTRA_PROBES = fcs_pkg::EXTRA_PROBES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  fcs_pkg::t_item   i_item,
    output logic             o_pop,
    input  fcs_pkg::t_cfg    i_cfg,
    output logic             o_res_valid,
    output fcs_pkg::t_result o_res,
    input  logic             i_res_ready
);

    localparam int AW = $clog2(GRID_CELLS);
    localparam int PW = $clog2(EXTRA_PROBES + 1);

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_NORM = 5'd1;
    localparam logic [4:0] S_SQA  = 5'd2;
    localparam logic [4:0] S_SQB  = 5'd3;
    localparam logic [4:0] S_SQC  = 5'd4;
    localparam logic [4:0] S_SQRT = 5'd5;
    localparam logic [4:0] S_UXS  = 5'd6;
    localparam logic [4:0] S_UXW  = 5'd7;
    localparam logic [4:0] S_UYW  = 5'd8;
    localparam logic [4:0] S_R0   = 5'd9;
    localparam logic [4:0] S_R1   = 5'd10;
    localparam logic [4:0] S_R2   = 5'd11;
    localparam logic [4:0] S_R3   = 5'd12;
    localparam logic [4:0] S_R4   = 5'd13;
    localparam logic [4:0] S_R5   = 5'd14;
    localparam logic [4:0] S_R6   = 5'd15;
    localparam logic [4:0] S_R7   = 5'd16;
    localparam logic [4:0] S_R8   = 5'd17;
    localparam logic [4:0] S_R9   = 5'd18;
    localparam logic [4:0] S_R10  = 5'd19;
    localparam logic [4:0] S_CXW  = 5'd20;
    localparam logic [4:0] S_CYW  = 5'd21;
    localparam logic [4:0] S_BND  = 5'd22;
    localparam logic [4:0] S_IDX  = 5'd23;
    localparam logic [4:0] S_CHK  = 5'd24;
    localparam logic [4:0] S_OUT  = 5'd25;

    logic [7:0] r_mem [GRID_CELLS];
    logic [7:0] r_rdata;

    logic [4:0]         r_state;
    logic signed [31:0] r_gx, r_gy;
    logic               r_dxneg, r_dyneg;
    logic [32:0]        r_ax, r_ay;
    logic signed [63:0] r_prod;
    logic [63:0]        r_acc;
    logic [63:0]        r_rad;
    logic [35:0]        r_rem;
    logic [31:0]        r_root;
    logic [4:0]         r_cnt;
    logic signed [31:0] r_ux, r_uy;
    logic [PW-1:0]      r_p;
    logic signed [63:0] r_ma, r_mb, r_mc;
    logic               r_rxn, r_ryn;
    logic [31:0]        r_rxm, r_rym;
    logic signed [33:0] r_ox, r_oy;
    logic signed [31:0] r_px, r_py;
    logic signed [32:0] r_dxc, r_dyc;
    logic [32:0]        r_qx, r_qy;
    logic               r_xneg, r_yneg;
    logic [17:0]        r_idx;
    logic               r_inb;
    fcs_pkg::t_result   r_res;

    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] prod_full;
    logic signed [32:0] dx, dy;
    logic [32:0]        adx, ady;
    logic [35:0]        rem_sh, trial;
    logic               sq_ge;
    logic [4:0]         ang;
    logic signed [31:0] cosv, sinv;
    logic [63:0]        abs_ma, abs_mc;
    logic [32:0]        abs_dxc, abs_dyc;
    logic [30:0]        cs_eff;
    fcs_pkg::t_div_req  div_req;
    logic               div_done;
    logic [fcs_pkg::DIV_DW-1:0] div_quo;
    logic               last_p;
    logic               idx_ok;
    logic               free;

    fcs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    assign o_pop       = (r_state == S_IDLE) && i_valid;
    assign o_res_valid = (r_state == S_OUT);
    assign o_res       = r_res;

    assign dx  = 33'(i_item.robot_x) - 33'(i_item.goal_x);
    assign dy  = 33'(i_item.robot_y) - 33'(i_item.goal_y);
    assign adx = dx[32] ? 33'(-dx) : 33'(dx);
    assign ady = dy[32] ? 33'(-dy) : 33'(dy);

    assign rem_sh = {r_rem[33:0], r_rad[63:62]};
    assign trial  = {2'b00, r_root, 2'b01};
    assign sq_ge  = (rem_sh >= trial);

    assign ang  = fcs_pkg::probe_angle(6'(r_p));
    assign cosv = fcs_pkg::cos_q30(ang);
    assign sinv = fcs_pkg::cos_q30(fcs_pkg::sin_index(ang));

    assign abs_ma  = r_ma[63] ? 64'(-r_ma) : 64'(r_ma);
    assign abs_mc  = r_mc[63] ? 64'(-r_mc) : 64'(r_mc);
    assign abs_dxc = r_dxc[32] ? 33'(-r_dxc) : 33'(r_dxc);
    assign abs_dyc = r_dyc[32] ? 33'(-r_dyc) : 33'(r_dyc);
    assign cs_eff  = (i_cfg.cell_size == 31'd0) ? 31'd1 : i_cfg.cell_size;

    assign last_p = (r_p == PW'(EXTRA_PROBES));
    assign idx_ok = (32'(r_idx) < 32'(GRID_CELLS));
    assign free   = (r_rdata != i_cfg.lethal_code) && (r_rdata != i_cfg.inscribed_code);

    // one shared multiplier, product registered
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_SQA: begin
                mul_a = $signed({2'b00, r_ax[30:0]});
                mul_b = $signed({2'b00, r_ax[30:0]});
            end
            S_SQB: begin
                mul_a = $signed({2'b00, r_ay[30:0]});
                mul_b = $signed({2'b00, r_ay[30:0]});
            end
            S_R0: begin
                mul_a = 33'(r_ux);
                mul_b = 33'(cosv);
            end
            S_R1: begin
                mul_a = 33'(r_uy);
                mul_b = 33'(sinv);
            end
            S_R2: begin
                mul_a = 33'(r_ux);
                mul_b = 33'(sinv);
            end
            S_R3: begin
                mul_a = 33'(r_uy);
                mul_b = 33'(cosv);
            end
            S_R6: begin
                mul_a = $signed({2'b00, i_cfg.probe_distance});
                mul_b = $signed({1'b0, r_rxm});
            end
            S_R7: begin
                mul_a = $signed({2'b00, i_cfg.probe_distance});
                mul_b = $signed({1'b0, r_rym});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_full = mul_a * mul_b;

    // divider requests
    always_comb begin
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;
        case (r_state)
            S_UXS: begin
                div_req.start    = 1'b1;
                div_req.dividend = {r_ax[30:0], 30'd0};
                div_req.divisor  = r_root;
            end
            S_UXW: begin
                div_req.start    = div_done;
                div_req.dividend = {r_ay[30:0], 30'd0};
                div_req.divisor  = r_root;
            end
            S_R10: begin
                div_req.start    = 1'b1;
                div_req.dividend = 61'(abs_dxc);
                div_req.divisor  = 32'(cs_eff);
            end
            S_CXW: begin
                div_req.start    = div_done;
                div_req.dividend = 61'(abs_dyc);
                div_req.divisor  = 32'(cs_eff);
            end
            default: begin
                div_req.start = 1'b0;
            end
        endcase
    end

    // cost store
    always_ff @(posedge i_clk) begin
        if (o_pop && i_item.req_type == fcs_pkg::REQ_WRITE && i_item.wr_ok) begin
            r_mem[AW'(i_item.cell_index)] <= i_item.cell_value;
        end
        if (r_state == S_IDX) begin
            r_rdata <= r_mem[AW'(r_idx)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_prod <= $signed(prod_full[63:0]);
            case (r_state)
                S_IDLE: begin
                    if (i_valid && i_item.req_type == fcs_pkg::REQ_SEARCH) begin
                        r_gx    <= i_item.goal_x;
                        r_gy    <= i_item.goal_y;
                        r_dxneg <= dx[32];
                        r_dyneg <= dy[32];
                        r_ax    <= adx;
                        r_ay    <= ady;
                        r_res.search_status <= fcs_pkg::ST_NONE;
                        r_res.free_x        <= '0;
                        r_res.free_y        <= '0;
                        r_res.probe_number  <= '0;
                        if (dx == 33'sd0 && dy == 33'sd0) begin
                            r_res.search_status <= fcs_pkg::ST_SAME;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_NORM;
                        end
                    end
                end
                S_NORM: begin
                    if (r_ax[32:31] != 2'b00 || r_ay[32:31] != 2'b00) begin
                        r_ax <= r_ax >> 1;
                        r_ay <= r_ay >> 1;
                    end else begin
                        r_state <= S_SQA;
                    end
                end
                S_SQA: begin
                    r_state <= S_SQB;
                end
                S_SQB: begin
                    r_acc   <= 64'(r_prod);
                    r_state <= S_SQC;
                end
                S_SQC: begin
                    r_rad   <= r_acc + 64'(r_prod);
                    r_rem   <= '0;
                    r_root  <= '0;
                    r_cnt   <= 5'd31;
                    r_state <= S_SQRT;
                end
                S_SQRT: begin
                    r_rad  <= {r_rad[61:0], 2'b00};
                    r_rem  <= sq_ge ? rem_sh - trial : rem_sh;
                    r_root <= {r_root[30:0], sq_ge};
                    r_cnt  <= r_cnt - 5'd1;
                    if (r_cnt == 5'd0) begin
                        r_state <= S_UXS;
                    end
                end
                S_UXS: begin
                    r_state <= S_UXW;
                end
                S_UXW: begin
                    if (div_done) begin
                        r_ux <= r_dxneg ? -$signed({1'b0, div_quo[30:0]})
                                        : $signed({1'b0, div_quo[30:0]});
                        r_state <= S_UYW;
                    end
                end
                S_UYW: begin
                    if (div_done) begin
                        r_uy <= r_dyneg ? -$signed({1'b0, div_quo[30:0]})
                                        : $signed({1'b0, div_quo[30:0]});
                        r_p     <= '0;
                        r_state <= S_R0;
                    end
                end
                S_R0: r_state <= S_R1;
                S_R1: begin
                    r_ma    <= r_prod;
                    r_state <= S_R2;
                end
                S_R2: begin
                    r_mb    <= r_prod;
                    r_state <= S_R3;
                end
                S_R3: begin
                    r_mc    <= r_prod;
                    r_state <= S_R4;
                end
                S_R4: begin
                    r_ma    <= r_ma - r_mb;
                    r_mc    <= r_mc + r_prod;
                    r_state <= S_R5;
                end
                S_R5: begin
                    r_rxn   <= r_ma[63];
                    r_ryn   <= r_mc[63];
                    r_rxm   <= abs_ma[61:30];
                    r_rym   <= abs_mc[61:30];
                    r_state <= S_R6;
                end
                S_R6: r_state <= S_R7;
                S_R7: begin
                    r_ox <= r_rxn ? -$signed({1'b0, r_prod[62:30]})
                                  : $signed({1'b0, r_prod[62:30]});
                    r_state <= S_R8;
                end
                S_R8: begin
                    r_oy <= r_ryn ? -$signed({1'b0, r_prod[62:30]})
                                  : $signed({1'b0, r_prod[62:30]});
                    r_px    <= fcs_pkg::sat32(35'(r_gx) + 35'(r_ox));
                    r_state <= S_R9;
                end
                S_R9: begin
                    r_py    <= fcs_pkg::sat32(35'(r_gy) + 35'(r_oy));
                    r_dxc   <= 33'(r_px) - 33'(i_cfg.origin_x);
                    r_state <= S_R10;
                end
                S_R10: begin
                    r_dyc   <= 33'(r_py) - 33'(i_cfg.origin_y);
                    r_state <= S_CXW;
                end
                S_CXW: begin
                    if (div_done) begin
                        r_qx    <= div_quo[32:0];
                        r_xneg  <= r_dxc[32] && (div_quo[32:0] != 33'd0);
                        r_state <= S_CYW;
                    end
                end
                S_CYW: begin
                    if (div_done) begin
                        r_qy    <= div_quo[32:0];
                        r_yneg  <= r_dyc[32] && (div_quo[32:0] != 33'd0);
                        r_state <= S_BND;
                    end
                end
                S_BND: begin
                    r_inb <= !r_xneg && !r_yneg
                             && (r_qx < 33'(i_cfg.grid_width))
                             && (r_qy < 33'(i_cfg.grid_height));
                    r_idx <= 18'(r_qy[8:0] * i_cfg.grid_width) + 18'(r_qx[8:0]);
                    r_state <= S_IDX;
                end
                S_IDX: begin
                    if (r_inb && idx_ok) begin
                        r_state <= S_CHK;
                    end else if (last_p) begin
                        r_state <= S_OUT;
                    end else begin
                        r_p     <= r_p + PW'(1);
                        r_state <= S_R0;
                    end
                end
                S_CHK: begin
                    if (free) begin
                        r_res.search_status <= fcs_pkg::ST_FOUND;
                        r_res.free_x        <= r_px;
                        r_res.free_y        <= r_py;
                        r_res.probe_number  <= 5'(r_p);
                        r_state <= S_OUT;
                    end else if (last_p) begin
                        r_state <= S_OUT;
                    end else begin
                        r_p     <= r_p + PW'(1);
                        r_state <= S_R0;
                    end
                end
                S_OUT: begin
                    if (i_res_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== rtl/free_cell_search_around_goal_top.sv =====
// free cell search around a goal point: top level with registers and result stage
// depends on fcs_pkg, fcs_front, fcs_back and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

// usage
// - request channel (i_in_valid / o_in_stall): each word is a grid cell write
//   (i_req_type 0) or a search (i_req_type 1); a word is taken when valid is
//   high and stall is low; a two-word queue sits in front of the engine
// - cell writes leave the queue one per cycle while no search runs, and give no result
// - a search gives one result word on o_out_valid / i_out_stall
// - a search runs the norm, the squares and the 32 step root, then two
//   divisions for the unit vector, then per probe the rotation and offset
//   and two divisions for the cell mapping, for up to EXTRA_PROBES + 1
//   probes; the shared bit-serial divider does every division
// - identical goal and robot points go straight to the result, with no root or division
// - while a search runs, the queue fills and then holds o_in_stall high
// - a stalled result word stays on the outputs; the engine waits for it
// - config port (i_cfg_valid / o_cfg_ready) is always ready; write only
//   while the block is idle
// - reset (i_rst_n low, synchronous) empties the queue, drops any result and
//   loads register defaults; the cost store is not cleared
module free_cell_search_around_goal_top #(
    parameter int GRID_CELLS   = fcs_pkg::GRID_CELLS_DEF,
    parameter int EXTRA_PROBES = fcs_pkg::EXTRA_PROBES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // request words
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_req_type,
    input  logic [15:0]        i_cell_index,
    input  logic [7:0]         i_cell_value,
    input  logic signed [31:0] i_goal_x,
    input  logic signed [31:0] i_goal_y,
    input  logic signed [31:0] i_robot_x,
    input  logic signed [31:0] i_robot_y,
    // result words
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_search_status,
    output logic signed [31:0] o_free_x,
    output logic signed [31:0] o_free_y,
    output logic [4:0]         o_probe_number,
    // register writes
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    fcs_pkg::t_item   in_item;
    fcs_pkg::t_item   q_item;
    logic             q_valid;
    logic             q_pop;
    fcs_pkg::t_cfg    r_cfg;
    fcs_pkg::t_result res;
    logic             res_valid;
    logic             res_ready;
    fcs_pkg::t_result r_out;
    logic             r_out_valid;

    // pack request fields, the front end fills in the range flag
    always_comb begin
        in_item.req_type   = i_req_type;
        in_item.wr_ok      = 1'b0;
        in_item.cell_index = i_cell_index;
        in_item.cell_value = i_cell_value;
        in_item.goal_x     = i_goal_x;
        in_item.goal_y     = i_goal_y;
        in_item.robot_x    = i_robot_x;
        in_item.robot_y    = i_robot_y;
    end

    fcs_front #(
        .GRID_CELLS (GRID_CELLS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_item  (in_item),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_pop   (q_pop)
    );

    fcs_back #(
        .GRID_CELLS   (GRID_CELLS),
        .EXTRA_PROBES (EXTRA_PROBES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .i_item      (q_item),
        .o_pop       (q_pop),
        .i_cfg       (r_cfg),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (res_ready)
    );

    // register file, writes take effect at once
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.origin_x       <= '0;
            r_cfg.origin_y       <= '0;
            r_cfg.cell_size      <= fcs_pkg::CELL_SIZE_RST;
            r_cfg.grid_width     <= fcs_pkg::GRID_W_RST;
            r_cfg.grid_height    <= fcs_pkg::GRID_H_RST;
            r_cfg.probe_distance <= fcs_pkg::PROBE_DIST_RST;
            r_cfg.lethal_code    <= fcs_pkg::LETHAL_RST;
            r_cfg.inscribed_code <= fcs_pkg::INSCRIBED_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                fcs_pkg::CFG_ORIGIN_X:   r_cfg.origin_x       <= $signed(i_cfg_data);
                fcs_pkg::CFG_ORIGIN_Y:   r_cfg.origin_y       <= $signed(i_cfg_data);
                fcs_pkg::CFG_CELL_SIZE:  r_cfg.cell_size      <= i_cfg_data[30:0];
                fcs_pkg::CFG_GRID_W:     r_cfg.grid_width     <= i_cfg_data[8:0];
                fcs_pkg::CFG_GRID_H:     r_cfg.grid_height    <= i_cfg_data[8:0];
                fcs_pkg::CFG_PROBE_DIST: r_cfg.probe_distance <= i_cfg_data[30:0];
                fcs_pkg::CFG_LETHAL:     r_cfg.lethal_code    <= i_cfg_data[7:0];
                fcs_pkg::CFG_INSCRIBED:  r_cfg.inscribed_code <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // output register: loads when empty or when the word on it is taken
    assign res_ready = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (res_ready) begin
                r_out_valid <= res_valid;
                if (res_valid) begin
                    r_out <= res;
                end
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_search_status = r_out.search_status;
    assign o_free_x        = r_out.free_x;
    assign o_free_y        = r_out.free_y;
    assign o_probe_number  = r_out.probe_number;

    // checks
    `FCS_ASSERT_IMP(a_status_code, o_out_valid,
        o_search_status == fcs_pkg::ST_FOUND || o_search_status == fcs_pkg::ST_NONE ||
        o_search_status == fcs_pkg::ST_SAME, "bad search status")
    `FCS_ASSERT_IMP(a_empty_fields,
        o_out_valid && o_search_status != fcs_pkg::ST_FOUND,
        o_free_x == 32'sd0 && o_free_y == 32'sd0 && o_probe_number == 5'd0,
        "fields set on a failed search")
    `FCS_ASSERT_IMP(a_probe_range, o_out_valid && o_search_status == fcs_pkg::ST_FOUND,
        32'(o_probe_number) <= EXTRA_PROBES, "probe number out of range")
    `FCS_ASSERT_NXT(a_res_hold, res_valid && !res_ready,
        res_valid && $stable(res), "engine dropped a waiting result")

endmodule

// ===== sim/free_cell_search_around_goal_top_tb.sv =====
// testbench for free_cell_search_around_goal_top: cost grid writes, goal searches
// depends on fcs_pkg and the rtl of the block; self-checking against its own predictor
`timescale 1ns / 1ps

// predicts search results from its own copy of the grid and the registers
class free_cell_scoreboard;
    byte unsigned     cost [65536];
    bit               written [65536];
    longint           org_x, org_y;
    longint unsigned  csize, gw, gh, pdist, lethal, inscribed;
    fcs_pkg::t_result pending_results[$];
    int               n_mism, n_results, n_found, n_none, n_same, n_writes;

    function new();
        org_x = 0; org_y = 0; csize = 3277; gw = 256; gh = 256;
        pdist = 26214; lethal = 254; inscribed = 253;
    endfunction

    function void set_register(logic [2:0] idx, logic [31:0] d);
        case (idx)
            fcs_pkg::CFG_ORIGIN_X:   org_x = longint'($signed(d));
            fcs_pkg::CFG_ORIGIN_Y:   org_y = longint'($signed(d));
            fcs_pkg::CFG_CELL_SIZE:  csize = d[30:0];
            fcs_pkg::CFG_GRID_W:     gw = d[8:0];
            fcs_pkg::CFG_GRID_H:     gh = d[8:0];
            fcs_pkg::CFG_PROBE_DIST: pdist = d[30:0];
            fcs_pkg::CFG_LETHAL:     lethal = d[7:0];
            fcs_pkg::CFG_INSCRIBED:  inscribed = d[7:0];
            default: ;
        endcase
    endfunction

    function longint unsigned root(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // cos of k * 18 degrees, q2.30
    function longint turn_cos(int k);
        longint base [6];
        base = '{fcs_pkg::COS_0, fcs_pkg::COS_18, fcs_pkg::COS_36,
                 fcs_pkg::COS_54, fcs_pkg::COS_72, 0};
        k = k % 20;
        if (k <= 5) return base[k];
        if (k <= 10) return -base[10 - k];
        if (k <= 15) return -base[k - 10];
        return base[20 - k];
    endfunction

    function longint tz_shift(longint v);
        return (v < 0) ? -((-v) >>> 30) : (v >>> 30);
    endfunction

    function longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // the twenty probe points; returns 0 for identical points
    function bit probe_points(longint gx, gy, rx, ry, output longint px[20], py[20]);
        longint dx, dy, ux, uy, c, s, tx, ty, ox, oy;
        longint unsigned ax, ay, mag;
        int m, a;
        dx = rx - gx;
        dy = ry - gy;
        if (dx == 0 && dy == 0) return 0;
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        while (ax >= 64'h8000_0000 || ay >= 64'h8000_0000) begin
            ax = ax >> 1;
            ay = ay >> 1;
        end
        mag = root(ax * ax + ay * ay);
        ux = (ax << 30) / mag;
        uy = (ay << 30) / mag;
        if (dx < 0) ux = -ux;
        if (dy < 0) uy = -uy;
        for (int p = 0; p < 20; p++) begin
            m = p / 2;
            a = (p >= 2 && p % 2 == 0) ? (20 - m % 20) % 20 : m % 20;
            c = turn_cos(a);
            s = turn_cos(a + 15);
            tx = tz_shift(ux * c - uy * s);
            ty = tz_shift(ux * s + uy * c);
            ox = longint'((pdist * ((tx < 0) ? -tx : tx)) >> 30);
            oy = longint'((pdist * ((ty < 0) ? -ty : ty)) >> 30);
            px[p] = clamp32(gx + ((tx < 0) ? -ox : ox));
            py[p] = clamp32(gy + ((ty < 0) ? -oy : oy));
        end
        return 1;
    endfunction

    // grid address of a point, -1 when out of bounds
    function int cell_of(longint px, py);
        longint cs, cx, cy, idx;
        cs = (csize == 0) ? 1 : longint'(csize);
        cx = (px - org_x) / cs;
        cy = (py - org_y) / cs;
        if (cx < 0 || cy < 0 || cx >= longint'(gw) || cy >= longint'(gh)) return -1;
        idx = cy * longint'(gw) + cx;
        if (idx >= 65536) return -1;
        return int'(idx);
    endfunction

    function void note_word(bit kind, logic [15:0] idx, logic [7:0] val,
                            longint gx, gy, rx, ry);
        fcs_pkg::t_result r;
        longint px[20], py[20];
        int c;
        if (kind == fcs_pkg::REQ_WRITE) begin
            cost[idx] = val;
            written[idx] = 1;
            n_writes++;
            return;
        end
        r = '0;
        r.search_status = fcs_pkg::ST_NONE;
        if (!probe_points(gx, gy, rx, ry, px, py)) begin
            r.search_status = fcs_pkg::ST_SAME;
        end else begin
            for (int p = 0; p < 20; p++) begin
                c = cell_of(px[p], py[p]);
                if (c >= 0 && cost[c] != lethal && cost[c] != inscribed) begin
                    r.search_status = fcs_pkg::ST_FOUND;
                    r.free_x = px[p][31:0];
                    r.free_y = py[p][31:0];
                    r.probe_number = p[4:0];
                    break;
                end
            end
        end
        pending_results.push_back(r);
    endfunction

    function void check_result(fcs_pkg::t_result got);
        fcs_pkg::t_result want;
        if (pending_results.size() == 0) begin
            n_mism++;
            if (n_mism <= 10) $display("unexpected result word %p", got);
            return;
        end
        want = pending_results.pop_front();
        n_results++;
        case (want.search_status)
            fcs_pkg::ST_FOUND: n_found++;
            fcs_pkg::ST_NONE:  n_none++;
            default:           n_same++;
        endcase
        if (got.search_status !== want.search_status || got.free_x !== want.free_x ||
            got.free_y !== want.free_y || got.probe_number !== want.probe_number) begin
            n_mism++;
            if (n_mism <= 10)
                $display("result %0d mismatch: expected st=%0d x=%0d y=%0d p=%0d, got st=%0d x=%0d y=%0d p=%0d",
                         n_results, want.search_status, want.free_x, want.free_y,
                         want.probe_number, got.search_status, got.free_x, got.free_y,
                         got.probe_number);
        end
    endfunction
endclass

module free_cell_search_around_goal_top_tb;
    import fcs_pkg::*;

    localparam int IDLE_LIMIT = 40000; // covers the worst search plus stalls
    localparam int PHASE_WORDS = 290;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic               i_req_type = 1'b0;
    logic [15:0]        i_cell_index = '0;
    logic [7:0]         i_cell_value = '0;
    logic signed [31:0] i_goal_x = '0;
    logic signed [31:0] i_goal_y = '0;
    logic signed [31:0] i_robot_x = '0;
    logic signed [31:0] i_robot_y = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [1:0]         o_search_status;
    logic signed [31:0] o_free_x;
    logic signed [31:0] o_free_y;
    logic [4:0]         o_probe_number;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index = '0;
    logic [31:0]        i_cfg_data = '0;

    free_cell_scoreboard sb = new();
    int  idle_cycles = 0;
    int  words_sent = 0;
    int  burst_left = 0;
    int  stall_mode = 0;
    int  stall_left = 0;

    always #1 i_clk = ~i_clk;

    free_cell_search_around_goal_top u_top (.*);

    // result side: check accepted words, stall on a pattern, watch for a hang
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result('{o_search_status, o_free_x, o_free_y, o_probe_number});
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
        // stall pattern: quiet stretches, light stalling and heavy stalling
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 2);
            stall_left <= $urandom_range(20, 200);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0:       i_out_stall <= 1'b0;
            1:       i_out_stall <= ($urandom_range(0, 3) == 0);
            default: i_out_stall <= ($urandom_range(0, 2) != 0);
        endcase
    end

    // one request word; leaves valid high, or lowers it for a random gap after a burst
    task automatic send_word(bit kind, logic [15:0] idx, logic [7:0] val,
                             longint gx, gy, rx, ry);
        i_in_valid   <= 1'b1;
        i_req_type   <= kind;
        i_cell_index <= idx;
        i_cell_value <= val;
        i_goal_x     <= gx[31:0];
        i_goal_y     <= gy[31:0];
        i_robot_x    <= rx[31:0];
        i_robot_y    <= ry[31:0];
        do @(posedge i_clk); while (o_in_stall);
        sb.note_word(kind, idx, val, gx, gy, rx, ry);
        words_sent++;
        // bursts of random length, random gaps between them
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 3) != 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
        end else begin
            burst_left--;
        end
    endtask

    // fill mode: 0 biased random on unwritten cells, 1 all blocked, 2 all free
    task automatic search(longint gx, gy, rx, ry, int fill);
        longint px[20], py[20];
        int c;
        logic [7:0] v;
        if (sb.probe_points(gx, gy, rx, ry, px, py)) begin
            for (int p = 0; p < 20; p++) begin
                c = sb.cell_of(px[p], py[p]);
                if (c >= 0 && (fill != 0 || !sb.written[c])) begin
                    case (fill)
                        1: v = p[0] ? sb.lethal[7:0] : sb.inscribed[7:0];
                        2: v = sb.lethal[7:0] ^ sb.inscribed[7:0] ^ 8'h5A;
                        default: v = ($urandom_range(0, 4) < 3)
                            ? (($urandom_range(0, 1) != 0) ? sb.lethal[7:0] : sb.inscribed[7:0])
                            : $urandom();
                    endcase
                    if (fill == 2 && (v == sb.lethal[7:0] || v == sb.inscribed[7:0]))
                        v = 8'd0;
                    if (fill == 2 && (v == sb.lethal[7:0] || v == sb.inscribed[7:0]))
                        v = 8'd1;
                    send_word(REQ_WRITE, c[15:0], v, 0, 0, 0, 0);
                end
            end
        end
        send_word(REQ_SEARCH, $urandom(), $urandom(), gx, gy, rx, ry);
    endtask

    // sender pause until every result is home, then let queued writes drain
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic set_registers(logic [31:0] ox, oy, cs, w, h, pd, le, ins);
        logic [31:0] vals [8];
        vals = '{ox, oy, cs, w, h, pd, le, ins};
        wait_idle();
        for (int k = 0; k < 8; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= k[2:0];
            i_cfg_data  <= vals[k];
            do @(posedge i_clk); while (!o_cfg_ready);
            sb.set_register(k[2:0], vals[k]);
            i_cfg_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    function automatic longint rand_coord();
        return longint'($signed($urandom()));
    endfunction

    // writes and searches; goal mostly in the grid, robot close, random or on top
    task automatic random_phase(int n_words);
        int stop, kind;
        longint cs, span, gx, gy, rx, ry, reach;
        stop = words_sent + n_words;
        while (words_sent < stop) begin
            kind = $urandom_range(0, 9);
            if (kind < 3) begin
                send_word(REQ_WRITE, $urandom(), $urandom(), 0, 0, 0, 0);
            end else if (kind == 3) begin
                // noise: anything at all
                search(rand_coord(), rand_coord(), rand_coord(), rand_coord(), 0);
            end else begin
                cs = (sb.csize == 0) ? 1 : longint'(sb.csize);
                span = cs * longint'(sb.gw);
                gx = sb.clamp32(sb.org_x + longint'({$urandom(), $urandom()} % span));
                span = cs * longint'(sb.gh);
                gy = sb.clamp32(sb.org_y + longint'({$urandom(), $urandom()} % span));
                reach = longint'(sb.pdist) * 4 + 10;
                if (reach > 64'sd4000000000) reach = 64'sd4000000000;
                case ($urandom_range(0, 9))
                    0: begin rx = gx; ry = gy; end
                    1: begin rx = rand_coord(); ry = rand_coord(); end
                    default: begin
                        rx = sb.clamp32(gx + ($urandom_range(0, 1) ? 1 : -1) *
                                        longint'({$urandom(), $urandom()} % reach));
                        ry = sb.clamp32(gy + ($urandom_range(0, 1) ? 1 : -1) *
                                        longint'({$urandom(), $urandom()} % reach));
                    end
                endcase
                search(gx, gy, rx, ry, ($urandom_range(0, 9) == 0) ? 1 : 0);
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed words under the reset settings
        send_word(REQ_WRITE, 16'h0000, 8'h00, 0, 0, 0, 0);
        send_word(REQ_WRITE, 16'hFFFF, 8'hFF, 0, 0, 0, 0);
        // identical points, at both ends of the range
        search(64'sd100000, 64'sd200000, 64'sd100000, 64'sd200000, 0);
        search(-64'sd2147483648, 64'sd2147483647, -64'sd2147483648, 64'sd2147483647, 0);
        // every probe blocked, then the first probe free
        search(64'sd300000, 64'sd300000, 64'sd400000, 64'sd350000, 1);
        search(64'sd300000, 64'sd300000, 64'sd400000, 64'sd350000, 2);
        // goal well outside the grid: nothing in bounds
        search(-64'sd2000000, -64'sd2000000, -64'sd1000000, -64'sd2000000, 0);
        // opposite extremes: long difference vector halved before the root
        search(64'sd2147483647, 64'sd2147483647, -64'sd2147483648, -64'sd2147483648, 0);
        search(64'sd2147483647, 0, 64'sd2147483646, 0, 0);
        search(64'sd600000, 64'sd600000, 64'sd600000, 64'sd600001, 0);

        random_phase(PHASE_WORDS);

        // shifted grid, both origins away from zero
        set_registers(-32'sd3276800, 32'sd1000000, 32'd6554, 32'd200, 32'd150,
                      32'd52428, 32'd254, 32'd253);
        random_phase(PHASE_WORDS);
        // zero cell size, single column grid, zero probe distance
        set_registers(32'h8000_0000, 32'h7FFF_0000, 32'd0, 32'd1, 32'd256,
                      32'd0, 32'd0, 32'd255);
        search(-64'sd2147483648, 64'sd2147418112, 64'sd5, 64'sd2147418200, 2);
        random_phase(PHASE_WORDS);
        // largest cell size and probe distance, single row grid
        set_registers(32'h0000_0000, 32'h0000_0000, 32'h7FFF_FFFF, 32'd256, 32'd1,
                      32'h7FFF_FFFF, 32'd255, 32'd0);
        random_phase(PHASE_WORDS);
        // grid larger than the store: addresses past the end count as blocked
        set_registers(32'd0, 32'd0, 32'd1000, 32'd511, 32'd256, 32'd5000,
                      32'd200, 32'd100);
        random_phase(PHASE_WORDS);
        // small grid of one meter cells
        set_registers(32'hFFFF_0000, 32'h0001_0000, 32'd65536, 32'd16, 32'd16,
                      32'd196608, 32'd254, 32'd253);
        random_phase(PHASE_WORDS);

        wait_idle();
        repeat (50) @(posedge i_clk);
        $display("covered %0d request words: %0d cell writes, %0d searches over six grid settings",
                 words_sent, sb.n_writes, sb.n_results);
        $display("search outcomes: %0d free, %0d none free, %0d identical; %0d mismatches",
                 sb.n_found, sb.n_none, sb.n_same, sb.n_mism);
        if (sb.n_mism == 0 && sb.pending_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/fcs_pkg.sv
rtl/fcs_front.sv
rtl/fcs_div.sv
rtl/fcs_back.sv
rtl/free_cell_search_around_goal_top.sv
sim/free_cell_search_around_goal_top_tb.sv
